// ----- src/rcl_pkg.sv -----
// shared constants, codes and control types for the ranked character list engine
`timescale 1ns / 1ps
`default_nettype none

package rcl_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_PRINT  = 2'd3;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       insert;
        logic       remove;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        logic       idx_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       pos_ok;
        logic       out_free;
        logic       print_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/ranked_char_list_engine.sv -----
// add/delete change the list in the check state; get loads its beat there once output is free
// print takes count+1 output beats, one per cycle while m_ready is high, after the check state
// a new command is accepted only when idle, after the last one has issued all of its beats
// the parallel shift array moves all entries at once; output is one beat register
// synchronous active-low reset clears the entry count and output valid; entries stay undefined
`timescale 1ns / 1ps
`default_nettype none

module ranked_char_list_engine
    import rcl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [5:0] s_position,
    input  wire logic [7:0] s_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_character,
    output logic            m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcl_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_op        (s_op),
        .s_position  (s_position),
        .s_value     (s_value),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

// ----- src/rcl_ctrl.sv -----
// command sequencer for the ranked character list engine
`timescale 1ns / 1ps
`default_nettype none

module rcl_ctrl
    import rcl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_PRINT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = KIND_CHAR;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.op == OP_PRINT) begin
                    state_next = ST_PRINT;
                end else if (!stat.pos_ok) begin
                    if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_ERROR;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    case (stat.op)
                        OP_ADD: begin
                            cmd.insert = 1'b1;
                            state_next = ST_IDLE;
                        end
                        OP_DELETE: begin
                            cmd.remove = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default: begin
                            if (stat.out_free) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_CHAR;
                                cmd.emit_last = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_PRINT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.print_done) begin
                        cmd.emit_kind = KIND_END;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.emit_kind = KIND_CHAR;
                        cmd.idx_inc   = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rcl_datapath.sv -----
// shift array, entry count, read index and output beat register
`timescale 1ns / 1ps
`default_nettype none

module rcl_datapath
    import rcl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] s_op,
    input  wire logic [5:0] s_position,
    input  wire logic [7:0] s_value,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_character,
    output logic            m_last
);

    logic [7:0]       entries_reg [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       op_reg;
    logic [5:0]       pos_reg;
    logic [7:0]       value_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             m_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic [7:0]       rd_data;
    logic [6:0]       pos_ext;
    logic [6:0]       cnt_ext;
    logic             pos_ok;

    assign pos_ext = {1'b0, pos_reg};
    assign cnt_ext = 7'(count_reg);

    always_comb begin
        case (op_reg)
            OP_ADD: begin
                pos_ok = (pos_reg != 6'd0) && (pos_ext <= cnt_ext + 7'd1) &&
                         (cnt_ext < 7'(CAPACITY));
            end
            OP_DELETE, OP_GET: begin
                pos_ok = (pos_reg != 6'd0) && (pos_ext <= cnt_ext);
            end
            default: begin
                pos_ok = 1'b1;
            end
        endcase
    end

    assign rd_data = entries_reg[idx_reg[IDX_W-1:0]];

    assign stat.op         = op_reg;
    assign stat.pos_ok     = pos_ok;
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.print_done = (idx_reg == count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.capture) begin
            if (s_op == OP_PRINT) begin
                idx_next = '0;
            end else begin
                idx_next = CNT_W'(s_position - 6'd1);
            end
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    // insert opens a gap at the read index, delete closes it
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (cmd.insert) begin
                if (CNT_W'(i) == idx_reg) begin
                    entries_reg[i] <= value_reg;
                end else if (i > 0 && CNT_W'(i) > idx_reg) begin
                    entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.remove) begin
                if (i < CAPACITY - 1 && CNT_W'(i) >= idx_reg) begin
                    entries_reg[i] <= entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg <= cmd.emit_kind;
            last_reg <= cmd.emit_last;
            char_reg <= (cmd.emit_kind == KIND_CHAR) ? rd_data : 8'd0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the count");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("pending output beat overwritten");

    a_insert_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> count_reg < CNT_W'(CAPACITY))
        else $error("insert into full list");
`endif

endmodule

`default_nettype wire

// ----- test/ranked_char_list_engine_check.sv -----
// checker for the ranked character list engine: predicts result beats and compares them
`timescale 1ns / 1ps

module ranked_char_list_engine_check
    import rcl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [5:0] s_position,
    input  wire logic [7:0] s_value,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [1:0] m_kind,
    input  wire logic [7:0] m_character,
    input  wire logic       m_last,
    output int              fail_count,
    output int              pending,
    output int              list_len
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] character;
        logic       last;
    } beat_t;

    logic [7:0] chars [CAPACITY];
    int         entries;
    beat_t      expected_beats [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        list_len   = 0;
        entries    = 0;
    end

    function automatic beat_t make_beat(input logic [1:0] kind, input logic [7:0] ch,
                                        input logic last);
        beat_t b;
        b.kind      = kind;
        b.character = ch;
        b.last      = last;
        return b;
    endfunction

    task automatic apply_command(input logic [1:0] op, input logic [5:0] position,
                                 input logic [7:0] value);
        int n;
        int p;
        int i;
        n = entries;
        p = position;
        case (op)
            OP_ADD: begin
                if (p == 0 || p > n + 1 || n >= CAPACITY) begin
                    expected_beats.push_back(make_beat(KIND_ERROR, 8'h00, 1'b1));
                end else begin
                    for (i = n; i > p - 1; i--) chars[i] = chars[i - 1];
                    chars[p - 1] = value;
                    entries = n + 1;
                end
            end
            OP_DELETE: begin
                if (p == 0 || p > n) begin
                    expected_beats.push_back(make_beat(KIND_ERROR, 8'h00, 1'b1));
                end else begin
                    for (i = p - 1; i + 1 < n; i++) chars[i] = chars[i + 1];
                    entries = n - 1;
                end
            end
            OP_GET: begin
                if (p == 0 || p > n) begin
                    expected_beats.push_back(make_beat(KIND_ERROR, 8'h00, 1'b1));
                end else begin
                    expected_beats.push_back(make_beat(KIND_CHAR, chars[p - 1], 1'b1));
                end
            end
            default: begin
                for (i = 0; i < n; i++) begin
                    expected_beats.push_back(make_beat(KIND_CHAR, chars[i], 1'b0));
                end
                expected_beats.push_back(make_beat(KIND_END, 8'h00, 1'b1));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (!aresetn) begin
            entries = 0;
            expected_beats.delete();
        end else begin
            if (s_valid && s_ready) apply_command(s_op, s_position, s_value);
            if (m_valid && m_ready) begin
                got = make_beat(m_kind, m_character, m_last);
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: kind %0d char %02h last %0d",
                                 got.kind, got.character, got.last);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %0d %02h %0d, got %0d %02h %0d",
                                     want.kind, want.character, want.last,
                                     got.kind, got.character, got.last);
                        end
                    end
                end
            end
        end
        pending  = expected_beats.size();
        list_len = entries;
    end

endmodule

// ----- test/ranked_char_list_engine_test.sv -----
// testbench top for the ranked character list engine: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module ranked_char_list_engine_test;
    import rcl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 230;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = OP_ADD;
    logic [5:0] s_position = 6'd0;
    logic [7:0] s_value = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_character;
    logic       m_last;

    int fail_count;
    int pending;
    int list_len;
    int cycles = 0;
    bit burst = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #2 aclk = ~aclk;

    ranked_char_list_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_character (m_character),
        .m_last      (m_last)
    );

    ranked_char_list_engine_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_character (m_character),
        .m_last      (m_last),
        .fail_count  (fail_count),
        .pending     (pending),
        .list_len    (list_len)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // starts and ends at a falling edge; valid stays high after the beat until the next call
    task automatic send(input logic [1:0] op, input logic [5:0] position,
                        input logic [7:0] value);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op       = op;
        s_position = position;
        s_value    = value;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic pick_command(input int mode, output logic [1:0] op,
                                output logic [5:0] position);
        int roll;
        int n;
        n    = list_len;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            op       = 2'($urandom_range(0, 3));
            position = 6'($urandom_range(0, 63));
        end else if (roll < 15) begin
            op       = OP_PRINT;
            position = 6'($urandom_range(0, 63));
        end else begin
            case (mode)
                MODE_GROW:   op = roll < 75 ? OP_ADD : (roll < 90 ? OP_GET : OP_DELETE);
                MODE_SHRINK: op = roll < 75 ? OP_DELETE : (roll < 90 ? OP_GET : OP_ADD);
                default:     op = roll < 45 ? OP_GET : (roll < 75 ? OP_ADD : OP_DELETE);
            endcase
            if (op == OP_ADD) position = 6'($urandom_range(1, n + 1));
            else if (n == 0) position = 6'd1;
            else position = 6'($urandom_range(1, n));
        end
    endtask

    // receiver: random stall per beat, plus one long hold-off on request
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            stall = burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int k;
        int mode;
        logic [1:0] op;
        logic [5:0] position;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty list cases
        send(OP_PRINT, 6'd0, 8'h00);
        send(OP_GET, 6'd1, 8'h00);
        send(OP_DELETE, 6'd1, 8'h00);
        send(OP_ADD, 6'd0, 8'h11);
        send(OP_ADD, 6'd2, 8'h22);
        // build a short list with extreme characters
        send(OP_ADD, 6'd1, 8'h00);
        send(OP_ADD, 6'd2, 8'hFF);
        send(OP_ADD, 6'd1, 8'hA5);
        send(OP_ADD, 6'd4, 8'h5A);
        send(OP_ADD, 6'd63, 8'hFF);
        send(OP_PRINT, 6'd63, 8'hFF);
        send(OP_GET, 6'd0, 8'h00);
        send(OP_GET, 6'd1, 8'hFF);
        send(OP_GET, 6'd4, 8'h00);
        send(OP_GET, 6'd5, 8'h00);
        send(OP_GET, 6'd63, 8'h00);
        send(OP_DELETE, 6'd0, 8'h00);
        send(OP_DELETE, 6'd63, 8'h00);
        send(OP_DELETE, 6'd4, 8'h00);
        send(OP_DELETE, 6'd1, 8'h00);
        send(OP_PRINT, 6'd0, 8'h00);
        send(OP_ADD, 6'd2, 8'h3C);
        send(OP_PRINT, 6'd21, 8'hC3);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k < 60) mode = MODE_GROW;
            else if (k < 110) mode = MODE_SHRINK;
            else if (k < 120) mode = MODE_GROW;
            else if (k < 150) mode = MODE_MIXED;
            else if (k < 190) mode = MODE_GROW;
            else mode = MODE_MIXED;
            if (k == 120) hold_req = 1'b1;
            burst = ((k % 50) < 12) || (k >= 120 && k < 150);
            pick_command(mode, op, position);
            send(op, position, 8'($urandom_range(0, 255)));
        end
        s_valid = 1'b0;
        burst   = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
